>>> sv/alst_pkg.sv
package alst_pkg;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 9;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [WORD_W-1:0] WORD_ERR = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHUP,
    S_SHDN,
    S_RDWAIT,
    S_DONE
  } alst_state_t;

endpackage

>>> sv/array_list_engine.sv
// Append, set, an unknown kind and any rejected request go straight to the done state; get
// waits in S_RDWAIT for the store read; insert and remove first shift the entries after the position.
// One item at a time: in_stall is high from acceptance until the result is
// registered, and a stalled output holds the result in the done state.
// Each shifted entry takes one read and one write of the store.
// Reset (rst_n low, synchronous) empties the list at once; the store is not cleared.
module array_list_engine #(
  parameter int CAPACITY = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [alst_pkg::KIND_W-1:0]   in_kind,
  input  logic [alst_pkg::POS_W-1:0]    in_position,
  input  logic [alst_pkg::WORD_W-1:0]   in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [alst_pkg::WORD_W-1:0]   out_read_data,
  output logic [alst_pkg::COUNT_W-1:0]  out_count,
  output logic [alst_pkg::STATUS_W-1:0] out_status
);
  import alst_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  alst_seq #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_position  (in_position),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_read_data(out_read_data),
    .out_count    (out_count),
    .out_status   (out_status),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  alst_mem #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

>>> sv/alst_mem.sv
module alst_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [alst_pkg::WORD_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [alst_pkg::WORD_W-1:0] rdata
);
  import alst_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/alst_seq.sv
module alst_seq #(
  parameter int CAPACITY = 256,
  parameter int AW       = 8,
  parameter int CW       = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [alst_pkg::KIND_W-1:0]   in_kind,
  input  logic [alst_pkg::POS_W-1:0]    in_position,
  input  logic [alst_pkg::WORD_W-1:0]   in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [alst_pkg::WORD_W-1:0]   out_read_data,
  output logic [alst_pkg::COUNT_W-1:0]  out_count,
  output logic [alst_pkg::STATUS_W-1:0] out_status,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [alst_pkg::WORD_W-1:0]   mem_wdata,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [alst_pkg::WORD_W-1:0]   mem_rdata
);
  import alst_pkg::*;

  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  alst_state_t state_r, state_nxt;

  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [WORD_W-1:0]   item_r, item_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       pend_addr_r, pend_addr_nxt;
  logic [WORD_W-1:0]   rd_r, rd_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_read_data_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [STATUS_W-1:0] out_status_r;

  logic          accept;
  logic          full;
  logic          pos_le_n;
  logic          pos_lt_n;
  logic          up_issue;
  logic          dn_issue;
  logic          out_load;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] n_x;
  logic [CW-1:0] idx_inc;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign pos_x    = XW'(in_position);
  assign n_x      = XW'(cnt_r);
  assign pos_le_n = (pos_x <= n_x);
  assign pos_lt_n = (pos_x < n_x);
  assign full     = (cnt_r == CAP_C);
  assign idx_inc  = idx_r + CW'(1);
  assign up_issue = (idx_r > CW'(pos_r));
  assign dn_issue = (idx_inc < cnt_r);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DONE;
          case (in_kind)
            KIND_INSERT: if (pos_le_n && !full) state_nxt = S_SHUP;
            KIND_REMOVE: if (pos_lt_n) state_nxt = S_SHDN;
            KIND_GET:    if (pos_lt_n) state_nxt = S_RDWAIT;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_SHUP:   if (!up_issue && !pend_r) state_nxt = S_DONE;
      S_SHDN:   if (!dn_issue && !pend_r) state_nxt = S_DONE;
      S_RDWAIT: state_nxt = S_DONE;
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    item_nxt      = item_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    rd_nxt        = rd_r;
    status_nxt    = status_r;
    mem_we        = 1'b0;
    mem_waddr     = pend_addr_r;
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = pos_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pos_nxt    = AW'(in_position);
          item_nxt   = in_item;
          rd_nxt     = '0;
          status_nxt = ST_OK;
          case (in_kind)
            KIND_APPEND: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cnt_r);
                mem_wdata = in_item;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            KIND_INSERT: begin
              if (!pos_le_n) begin
                status_nxt = ST_RANGE;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt = cnt_r;
              end
            end
            KIND_REMOVE: begin
              if (!pos_lt_n) begin
                status_nxt = ST_RANGE;
              end else begin
                idx_nxt = CW'(in_position);
              end
            end
            KIND_SET: begin
              if (!pos_lt_n) begin
                status_nxt = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_position);
                mem_wdata = in_item;
              end
            end
            KIND_GET: begin
              if (!pos_lt_n) begin
                status_nxt = ST_RANGE;
                rd_nxt     = WORD_ERR;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_position);
              end
            end
            default: status_nxt = ST_OK;
          endcase
        end
      end
      S_SHUP: begin
        if (pend_r) begin
          mem_we = 1'b1;
        end else if (!up_issue) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r;
          mem_wdata = item_r;
          cnt_nxt   = cnt_r + CW'(1);
        end
        if (up_issue) begin
          mem_re        = 1'b1;
          mem_raddr     = AW'(idx_r - CW'(1));
          pend_nxt      = 1'b1;
          pend_addr_nxt = AW'(idx_r);
          idx_nxt       = idx_r - CW'(1);
        end
      end
      S_SHDN: begin
        mem_we = pend_r;
        if (dn_issue) begin
          mem_re        = 1'b1;
          mem_raddr     = AW'(idx_inc);
          pend_nxt      = 1'b1;
          pend_addr_nxt = AW'(idx_r);
          idx_nxt       = idx_inc;
        end else if (!pend_r) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_RDWAIT: rd_nxt = mem_rdata;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pos_r       <= pos_nxt;
    item_r      <= item_nxt;
    pend_addr_r <= pend_addr_nxt;
    rd_r        <= rd_nxt;
    status_r    <= status_nxt;
    if (out_load) begin
      out_read_data_r <= rd_r;
      out_count_r     <= COUNT_W'(cnt_r);
      out_status_r    <= status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_count     = out_count_r;
  assign out_status    = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C)
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |->
      ((cnt_r == $past(cnt_r) + CW'(1)) || (cnt_r == $past(cnt_r) - CW'(1))))
    else $error("entry count moved by more than one");

  a_pend_shift: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ((state_r == S_SHUP) || (state_r == S_SHDN)))
    else $error("pending move outside a shift");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside completion");

endmodule
